// ===== hdl/aps_pkg.sv =====
package aps_pkg;

  // default geometry
  localparam int MEAN_LEN_DEF   = 32;
  localparam int NEIGHBOURS_DEF = 3;

  // field widths
  localparam int ACC_W   = 16;
  localparam int SQ_W    = 32;
  localparam int CHG_W   = SQ_W + 1;
  localparam int STEP_W  = 24;
  localparam int CNT_W   = 8;
  localparam int WARM_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PENDING_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_SAMPLES = 3'd4;

  // register reset values
  localparam logic [31:0]       THRESHOLD_RST = 32'd2306867;
  localparam logic [CNT_W-1:0]  IMIN_RST      = 8'd37;
  localparam logic [CNT_W-1:0]  IMAX_RST      = 8'd71;
  localparam logic [CNT_W-1:0]  PEND_LIM_RST  = 8'd10;
  localparam logic [WARM_W-1:0] WARMUP_RST    = 12'd547;

  typedef struct packed {
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
  } aps_in_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_total;
    logic              walking_now;
    logic              peak_seen;
    logic              warming_up;
  } aps_out_t;

  // interval tracker mode
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_HUNT,
    MODE_LOCK
  } aps_mode_t;

  // saturating 8-bit increment
  function automatic logic [CNT_W-1:0] sat_inc8(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

// ===== hdl/accel_peak_step_counter.sv =====
// channel   | dir | handshake              | payload
// ----------+-----+------------------------+--------------------------------
// in_       | in  | in_valid / in_ready    | aps_in_t  (x, y, z Q8.8)
// out_      | out | out_valid / out_ready  | aps_out_t (steps, flags)
// cfg_      | in  | cfg_we                 | cfg_idx, cfg_wdata
//
// One sample per cycle sustained while out_ready holds; the sample beat loads the input
// register, then the change window, then the result register.
// Square ring is a MEAN_LEN-deep memory with one write and one read port;
// a wrap flag stands in for its zero reset, so there is no clearing pass.
// Synchronous active-low reset clears control state, the configuration registers and the change window.
// A stalled result holds all stages behind it; in_ready falls only when full.
module accel_peak_step_counter
  import aps_pkg::*;
#(
  parameter int MEAN_LEN   = MEAN_LEN_DEF,
  parameter int NEIGHBOURS = NEIGHBOURS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aps_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aps_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int POS_W   = $clog2(MEAN_LEN);
  localparam int WIN_LEN = 2 * NEIGHBOURS + 1;
  localparam int SUM_W   = CHG_W + $clog2(NEIGHBOURS) + 1;

  // configuration registers
  logic [31:0]       thresh_r;
  logic [CNT_W-1:0]  imin_r;
  logic [CNT_W-1:0]  imax_r;
  logic [CNT_W-1:0]  pend_lim_r;
  logic [WARM_W-1:0] warmup_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r   <= THRESHOLD_RST;
      imin_r     <= IMIN_RST;
      imax_r     <= IMAX_RST;
      pend_lim_r <= PEND_LIM_RST;
      warmup_r   <= WARMUP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PEAK_THRESHOLD: thresh_r   <= cfg_wdata;
        CFG_INTERVAL_MIN:   imin_r     <= cfg_wdata[CNT_W-1:0];
        CFG_INTERVAL_MAX:   imax_r     <= cfg_wdata[CNT_W-1:0];
        CFG_PENDING_LIMIT:  pend_lim_r <= cfg_wdata[CNT_W-1:0];
        CFG_WARMUP_SAMPLES: warmup_r   <= cfg_wdata[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic a_v_r, c_v_r, out_valid_r;
  logic in_take, en_c, en_d;

  assign en_d     = c_v_r && (!out_valid_r || out_ready);
  assign en_c     = a_v_r && (!c_v_r || en_d);
  assign in_ready = !a_v_r || en_c;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready)                  a_v_r       <= in_valid;
      if (!c_v_r || en_d)            c_v_r       <= en_c;
      if (!out_valid_r || out_ready) out_valid_r <= en_d;
    end
  end

  // ring position and wrap flag
  logic [POS_W-1:0] ring_pos_r;
  logic             wrapped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_pos_r <= '0;
      wrapped_r  <= 1'b0;
    end else if (in_take) begin
      if (ring_pos_r == POS_W'(MEAN_LEN - 1)) begin
        ring_pos_r <= '0;
        wrapped_r  <= 1'b1;
      end else begin
        ring_pos_r <= ring_pos_r + 1'b1;
      end
    end
  end

  // input stage: sample, evicted square and its slot
  aps_in_t          in_r;
  logic [SQ_W-1:0]  rd_r;
  logic             old_ok_r;
  logic [POS_W-1:0] wr_pos_r;
  logic [SQ_W-1:0]  sq_mem [MEAN_LEN];
  logic [SQ_W-1:0]  sq;

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r     <= in_data;
      rd_r     <= sq_mem[ring_pos_r];
      old_ok_r <= wrapped_r;
      wr_pos_r <= ring_pos_r;
    end
    if (en_c) begin
      sq_mem[wr_pos_r] <= sq;
    end
  end

  // sum of squares and mean change
  logic signed [SQ_W-1:0]  xx, yy, zz;
  logic [SQ_W-1:0]         old_sq;
  logic signed [CHG_W-1:0] chg;

  assign xx     = $signed(in_r.accel_x) * $signed(in_r.accel_x);
  assign yy     = $signed(in_r.accel_y) * $signed(in_r.accel_y);
  assign zz     = $signed(in_r.accel_z) * $signed(in_r.accel_z);
  assign sq     = $unsigned(xx) + $unsigned(yy) + $unsigned(zz);
  assign old_sq = old_ok_r ? rd_r : '0;
  assign chg    = $signed({1'b0, sq}) - $signed({1'b0, old_sq});

  // centred change window, newest at index 0
  logic signed [CHG_W-1:0] win_r [WIN_LEN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else if (en_c) begin
      win_r[0] <= chg;
      for (int i = 1; i < WIN_LEN; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // peak test on the middle entry
  logic signed [CHG_W-1:0] cand;
  logic signed [SUM_W-1:0] newer, older, scaled;
  logic                    peak;

  assign cand = win_r[NEIGHBOURS];

  always_comb begin
    newer = '0;
    older = '0;
    for (int k = 0; k < NEIGHBOURS; k++) begin
      newer = newer + SUM_W'(win_r[k]);
      older = older + SUM_W'(win_r[NEIGHBOURS + 1 + k]);
    end
  end

  assign scaled = SUM_W'(cand) * $signed(SUM_W'(NEIGHBOURS));
  assign peak   = (cand > $signed({1'b0, thresh_r})) && (scaled > older) &&
                  (scaled > newer);

  // interval tracker state
  aps_mode_t               mode_r, mode_nxt;
  logic [WARM_W-1:0]       warm_r, warm_nxt;
  logic                    walk_r, walk_nxt;
  logic [CNT_W-1:0]        wcnt_r, wcnt_nxt;
  logic [CNT_W-1:0]        slock_r, slock_nxt;
  logic [CNT_W-1:0]        sbest_r, sbest_nxt;
  logic signed [CHG_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]        pend_r, pend_nxt;
  logic [STEP_W-1:0]       steps_r, steps_nxt;

  logic              warming;
  logic [CNT_W-1:0]  isize;
  logic              new_best;
  logic              lock_due;
  logic              lock_end;
  logic              best_pos;
  logic [STEP_W:0]   steps_sum;

  assign warming  = warm_r < warmup_r;
  assign isize    = (imax_r > imin_r) ? imax_r - imin_r : '0;
  assign new_best = (cand > best_r) && peak;
  assign lock_due = slock_r >= imin_r;
  assign lock_end = slock_r >= imax_r;
  assign best_pos = best_r > 0;

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    if (!warming) begin
      case (mode_r)
        MODE_IDLE: begin
          if (peak) mode_nxt = MODE_HUNT;
        end
        MODE_HUNT: begin
          if (wcnt_r >= isize) mode_nxt = MODE_LOCK;
        end
        MODE_LOCK: begin
          if (lock_due && lock_end && !best_pos && pend_r == '0) mode_nxt = MODE_IDLE;
        end
        default: mode_nxt = MODE_IDLE;
      endcase
    end
  end

  // counters, peak tracking and step total
  always_comb begin
    warm_nxt  = warm_r;
    walk_nxt  = walk_r;
    wcnt_nxt  = wcnt_r;
    slock_nxt = slock_r;
    sbest_nxt = sbest_r;
    best_nxt  = best_r;
    pend_nxt  = pend_r;
    steps_nxt = steps_r;
    steps_sum = '0;
    if (warming) begin
      warm_nxt = warm_r + 1'b1;
    end else begin
      case (mode_r)
        MODE_IDLE: begin
          if (peak) best_nxt = cand;
        end
        MODE_HUNT: begin
          if (wcnt_r >= isize) begin
            slock_nxt = sbest_r;
            best_nxt  = '0;
            wcnt_nxt  = '0;
            sbest_nxt = '0;
            pend_nxt  = sat_inc8(pend_r);
          end else if (new_best) begin
            best_nxt  = cand;
            sbest_nxt = '0;
            wcnt_nxt  = sat_inc8(wcnt_r);
          end else begin
            sbest_nxt = sat_inc8(sbest_r);
            wcnt_nxt  = sat_inc8(wcnt_r);
          end
        end
        MODE_LOCK: begin
          if (!lock_due) begin
            slock_nxt = sat_inc8(slock_r);
          end else if (lock_end) begin
            if (best_pos) begin
              slock_nxt = sbest_r;
              sbest_nxt = '0;
              best_nxt  = '0;
              if (walk_r) begin
                steps_sum = {1'b0, steps_r} + 1'b1;
                steps_nxt = steps_sum[STEP_W] ? STEP_MAX : steps_sum[STEP_W-1:0];
              end else if (pend_r == pend_lim_r) begin
                steps_sum = {1'b0, steps_r} + (STEP_W + 1)'(pend_lim_r);
                steps_nxt = steps_sum[STEP_W] ? STEP_MAX : steps_sum[STEP_W-1:0];
                walk_nxt  = 1'b1;
              end else begin
                pend_nxt = sat_inc8(pend_r);
              end
            end else if (pend_r != '0) begin
              sbest_nxt = '0;
              slock_nxt = isize >> 1;
              pend_nxt  = pend_r - 1'b1;
            end else begin
              walk_nxt = 1'b0;
            end
          end else if (new_best) begin
            best_nxt  = cand;
            sbest_nxt = '0;
            slock_nxt = sat_inc8(slock_r);
          end else begin
            slock_nxt = sat_inc8(slock_r);
            sbest_nxt = sat_inc8(sbest_r);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      warm_r  <= '0;
      walk_r  <= 1'b0;
      wcnt_r  <= '0;
      slock_r <= '0;
      sbest_r <= '0;
      best_r  <= '0;
      pend_r  <= '0;
      steps_r <= '0;
    end else if (en_d) begin
      mode_r  <= mode_nxt;
      warm_r  <= warm_nxt;
      walk_r  <= walk_nxt;
      wcnt_r  <= wcnt_nxt;
      slock_r <= slock_nxt;
      sbest_r <= sbest_nxt;
      best_r  <= best_nxt;
      pend_r  <= pend_nxt;
      steps_r <= steps_nxt;
    end
  end

  // result register
  aps_out_t out_r;

  always_ff @(posedge clk) begin
    if (en_d) begin
      out_r.step_total  <= steps_nxt;
      out_r.walking_now <= walk_nxt;
      out_r.peak_seen   <= peak;
      out_r.warming_up  <= warming;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // step total never goes down
  a_steps_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> steps_r >= $past(steps_r))
    else $error("step total decreased");

  // walking is only declared while locked on an interval
  a_walk_locked: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r |-> mode_r == MODE_LOCK)
    else $error("walking flag outside lock mode");

  // input back-pressure only when every stage holds a beat
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (a_v_r && c_v_r && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

endmodule
